[rtl/core/dfq_pkg.sv]
package dfq_pkg;

    localparam int DEPTH = 5;

    localparam logic [7:0] EMPTY_CODE = 8'h00;
    localparam logic [7:0] FREE_POS   = 8'hff;

    localparam logic [1:0] MODE_PUSH  = 2'd0;
    localparam logic [1:0] MODE_POP   = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic [1:0] ST_STORED = 2'd0;
    localparam logic [1:0] ST_DUP    = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_NONE   = 2'd3;

    typedef struct packed {
        logic [7:0] code;
        logic [7:0] position;
    } t_slot;

    localparam t_slot EMPTY_SLOT = '{code: EMPTY_CODE, position: FREE_POS};

    typedef struct packed {
        logic clear;
        logic shift;
        logic load;
    } t_cell_ctl;

    typedef struct packed {
        logic occupied;
        logic match;
    } t_cell_stat;

endpackage

[rtl/core/dfq_ifs.sv]
interface dfq_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] fault_code;
    logic [7:0] position;

    modport source (output valid, output mode, output fault_code, output position,
                    input ready);
    modport sink   (input valid, input mode, input fault_code, input position,
                    output ready);
endinterface

interface dfq_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] head_code;
    logic [7:0] head_position;
    logic [1:0] push_status;

    modport source (output valid, output head_code, output head_position,
                    output push_status, input ready);
    modport sink   (input valid, input head_code, input head_position,
                    input push_status, output ready);
endinterface

[rtl/core/dfq_cell.sv]
module dfq_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dfq_pkg::t_cell_ctl i_ctl,
    input  dfq_pkg::t_slot     i_next,
    input  dfq_pkg::t_slot     i_push,
    output dfq_pkg::t_slot     o_slot,
    output dfq_pkg::t_cell_stat o_stat
);
    import dfq_pkg::*;

    t_slot r_slot;
    t_slot n_slot;

    always_comb begin
        n_slot = r_slot;
        if (i_ctl.clear) begin
            n_slot = EMPTY_SLOT;
        end else if (i_ctl.shift) begin
            n_slot = i_next;
        end else if (i_ctl.load) begin
            n_slot = i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= EMPTY_SLOT;
        end else begin
            r_slot <= n_slot;
        end
    end

    assign o_slot          = r_slot;
    assign o_stat.occupied = (r_slot.code != EMPTY_CODE);
    assign o_stat.match    = (r_slot.code != EMPTY_CODE) && (r_slot.code == i_push.code);

endmodule

[rtl/core/dedup_fault_code_queue.sv]
// deduplicating fault-code queue, a row of DEPTH slot cells packed toward the head
// i_item (valid/ready): mode 0 push fault_code/position, 1 pop head, 2 clear, 3 no-op
// o_result (valid/ready): head code and position as they stood before the item,
//   plus push status (0 stored, 1 duplicate or empty code, 2 full, 3 not a push)
// every item gives exactly one result, in order
// the result is registered, valid in the cycle after the item is accepted
// throughput: one item per cycle while results are taken; the compare across all cells, the
//   first-free pick and the shift between neighbors all settle in that cycle
// i_item.ready is high while the result register is empty or being taken, so a
//   new item is accepted in the same cycle the previous result leaves
// a stalled receiver holds the result and blocks further items until it is taken
// synchronous active-low reset empties every slot (code EMPTY_CODE, position 255)
//   and drops any pending result; no clearing pass is needed
module dedup_fault_code_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    dfq_in_if.sink           i_item,
    dfq_out_if.source        o_result
);
    import dfq_pkg::*;

    t_slot      w_slot [DEPTH];
    t_slot      w_next [DEPTH];
    t_cell_stat w_stat [DEPTH];
    t_cell_ctl  w_ctl  [DEPTH];
    t_slot      w_push;

    logic [DEPTH-1:0] w_occ;
    logic [DEPTH-1:0] w_match;
    logic [DEPTH-1:0] w_prev_occ;
    logic             w_accept;
    logic             w_push_ok;
    logic [1:0]       w_status;

    logic       r_out_valid;
    logic [7:0] r_head_code;
    logic [7:0] r_head_position;
    logic [1:0] r_push_status;

    assign i_item.ready = !r_out_valid || o_result.ready;
    assign w_accept     = i_item.valid && i_item.ready;

    assign w_push.code     = i_item.fault_code;
    assign w_push.position = i_item.position;

    // slot i is the first free one when it is free and its head-side neighbor is taken
    assign w_prev_occ = {w_occ[DEPTH-2:0], 1'b1};

    always_comb begin
        w_status = ST_NONE;
        case (i_item.mode)
            MODE_PUSH: begin
                if (i_item.fault_code == EMPTY_CODE || (|w_match)) begin
                    w_status = ST_DUP;
                end else if (&w_occ) begin
                    w_status = ST_FULL;
                end else begin
                    w_status = ST_STORED;
                end
            end
            default: w_status = ST_NONE;
        endcase
    end

    assign w_push_ok = w_accept && (i_item.mode == MODE_PUSH) && (w_status == ST_STORED);

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            assign w_occ[g]   = w_stat[g].occupied;
            assign w_match[g] = w_stat[g].match;

            assign w_ctl[g].clear = w_accept && (i_item.mode == MODE_CLEAR);
            assign w_ctl[g].shift = w_accept && (i_item.mode == MODE_POP);
            assign w_ctl[g].load  = w_push_ok && !w_occ[g] && w_prev_occ[g];

            if (g == DEPTH - 1) begin : g_tail
                assign w_next[g] = EMPTY_SLOT;
            end else begin : g_body
                assign w_next[g] = w_slot[g+1];
            end

            dfq_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl[g]),
                .i_next  (w_next[g]),
                .i_push  (w_push),
                .o_slot  (w_slot[g]),
                .o_stat  (w_stat[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_head_code     <= w_slot[0].code;
            r_head_position <= w_slot[0].position;
            r_push_status   <= w_status;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.head_code     = r_head_code;
    assign o_result.head_position = r_head_position;
    assign o_result.push_status   = r_push_status;

endmodule
